// ===== rtl/sbcr_pkg.sv =====
// Shared constants and register codes for the swept box contact resolver.
`default_nettype none
package sbcr_pkg;
    localparam int DEF_COORD_BITS = 32;
    localparam int REG_BITS       = 16;
    localparam int REG_IDX_BITS   = 1;

    localparam logic [REG_BITS-1:0] GAP_RESET = 16'd1;
    localparam logic [REG_BITS-1:0] LIM_RESET = 16'd1;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_CONTACT_GAP = 1'b0,
        REG_NEAR_ZERO   = 1'b1
    } t_reg_idx;
endpackage
`default_nettype wire

// ===== rtl/sbcr_muldiv.sv =====
// Pipelined floor(a*b/c) plus base, saturated: split multiply, restoring divide.
`default_nettype none
module sbcr_muldiv #(
    parameter int COORD_BITS = sbcr_pkg::DEF_COORD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_neg,
    input  wire logic [COORD_BITS:0]          i_ua,
    input  wire logic [COORD_BITS+3:0]        i_ub,
    input  wire logic [COORD_BITS+1:0]        i_uc,
    input  wire logic signed [COORD_BITS-1:0] i_base,
    output logic signed [COORD_BITS-1:0]      o_val
);
    import sbcr_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int AW  = CW + 1;
    localparam int BW  = CW + 4;
    localparam int UW  = CW + 2;
    localparam int NW  = AW + BW;
    localparam int QB  = CW + 2;
    localparam int RW  = UW;
    localparam int HW  = NW - QB;
    localparam int BL  = (BW + 1) / 2;
    localparam int BH  = BW - BL;
    localparam int SQW = QB + 2;
    localparam int SUW = QB + 3;

    // multiply stage: two partial products
    logic [AW+BL-1:0]      r_p0;
    logic [AW+BH-1:0]      r_p1;
    logic                  r_m_neg;
    logic [UW-1:0]         r_m_uc;
    logic signed [CW-1:0]  r_m_base;

    always_ff @(posedge i_clk) begin
        r_p0     <= i_ua * i_ub[BL-1:0];
        r_p1     <= i_ua * i_ub[BW-1:BL];
        r_m_neg  <= i_neg;
        r_m_uc   <= i_uc;
        r_m_base <= i_base;
    end

    // product sum, overflow check and first partial remainder
    logic [NW-1:0] n_prod;
    logic          n_ovf;

    always_comb begin
        n_prod = NW'(r_p0) + (NW'(r_p1) << BL);
        n_ovf  = n_prod[NW-1:QB] >= HW'(r_m_uc);
    end

    logic [RW-1:0]        r_rem  [0:QB];
    logic [QB-1:0]        r_low  [0:QB];
    logic [QB-1:0]        r_quo  [0:QB];
    logic                 r_neg  [0:QB];
    logic                 r_ovf  [0:QB];
    logic [UW-1:0]        r_uc   [0:QB];
    logic signed [CW-1:0] r_base [0:QB];

    logic [RW:0]   n_trial [0:QB-1];
    logic          n_ge    [0:QB-1];
    logic [RW-1:0] n_rem   [0:QB-1];

    always_comb begin
        for (int k = 0; k < QB; k++) begin
            n_trial[k] = {r_rem[k], r_low[k][QB-1]};
            n_ge[k]    = n_trial[k] >= {1'b0, r_uc[k]};
            n_rem[k]   = n_ge[k] ? RW'(n_trial[k] - {1'b0, r_uc[k]}) : RW'(n_trial[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_ovf ? '0 : n_prod[QB+RW-1:QB];
        r_low[0]  <= n_prod[QB-1:0];
        r_quo[0]  <= '0;
        r_neg[0]  <= r_m_neg;
        r_ovf[0]  <= n_ovf;
        r_uc[0]   <= r_m_uc;
        r_base[0] <= r_m_base;
        for (int k = 0; k < QB; k++) begin
            r_rem[k+1]  <= n_rem[k];
            r_low[k+1]  <= {r_low[k][QB-2:0], 1'b0};
            r_quo[k+1]  <= {r_quo[k][QB-2:0], n_ge[k]};
            r_neg[k+1]  <= r_neg[k];
            r_ovf[k+1]  <= r_ovf[k];
            r_uc[k+1]   <= r_uc[k];
            r_base[k+1] <= r_base[k];
        end
    end

    // sign, floor correction, add base, saturate
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    logic signed [SQW-1:0] n_qs;
    logic signed [SUW-1:0] n_sum;
    logic signed [CW-1:0]  n_val;

    always_comb begin
        if (r_neg[QB]) begin
            n_qs = -($signed(SQW'(r_quo[QB])) +
                     $signed(SQW'(r_rem[QB] != '0)));
        end else begin
            n_qs = $signed(SQW'(r_quo[QB]));
        end
        n_sum = SUW'(r_base[QB]) + SUW'(n_qs);
        if (r_ovf[QB]) begin
            n_val = r_neg[QB] ? C_MIN : C_MAX;
        end else if (!n_sum[SUW-1] && (n_sum[SUW-2:CW-1] != '0)) begin
            n_val = C_MAX;
        end else if (n_sum[SUW-1] && !(&n_sum[SUW-2:CW-1])) begin
            n_val = C_MIN;
        end else begin
            n_val = n_sum[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_val <= n_val;
    end
endmodule
`default_nettype wire

// ===== rtl/swept_box_contact_resolve_top.sv =====
// Swept box contact resolver: broad phase, face contact and resolved position.
// Path: an item accepted at start passes the stage 0, stage 1 and stage 2 registers,
// the pipelined divider and the output register before it is shown on o_valid.
// Throughput: one item per cycle, busy stays low; every stage, one quotient bit
// per divider stage included, takes a new item each cycle.
// Reset: synchronous, active low; clears all valid bits, drops items in flight
// and sets contact_gap and near_zero_limit to 1. Results cannot be stalled.
`default_nettype none
module swept_box_contact_resolve_top #(
    parameter int COORD_BITS = sbcr_pkg::DEF_COORD_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [COORD_BITS-1:0]   i_prev_x,
    input  wire logic signed [COORD_BITS-1:0]   i_prev_y,
    input  wire logic signed [COORD_BITS-1:0]   i_next_x,
    input  wire logic signed [COORD_BITS-1:0]   i_next_y,
    input  wire logic [COORD_BITS-2:0]          i_mover_w,
    input  wire logic [COORD_BITS-2:0]          i_mover_h,
    input  wire logic signed [COORD_BITS-1:0]   i_obstacle_x,
    input  wire logic signed [COORD_BITS-1:0]   i_obstacle_y,
    input  wire logic [COORD_BITS-2:0]          i_obstacle_w,
    input  wire logic [COORD_BITS-2:0]          i_obstacle_h,
    input  wire logic                           i_cfg_we,
    input  wire logic [sbcr_pkg::REG_IDX_BITS-1:0] i_cfg_addr,
    input  wire logic [sbcr_pkg::REG_BITS-1:0]  i_cfg_data,
    output logic                                o_valid,
    output logic                                o_in_sweep,
    output logic                                o_hit,
    output logic                                o_hit_side,
    output logic signed [COORD_BITS-1:0]        o_out_x,
    output logic signed [COORD_BITS-1:0]        o_out_y
);
    import sbcr_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int DW  = CW + 1;   // motion
    localparam int XW  = CW + 2;   // doubled coordinates
    localparam int C2W = CW + 3;   // doubled contact coordinate
    localparam int BNW = CW + 4;   // line numerator term
    localparam int UCW = CW + 2;   // divisor magnitude
    localparam int SW  = CW - 1;   // sizes
    localparam int LAT = CW + 5;   // divider pipeline depth

    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    function automatic logic signed [CW-1:0] sat_c(input logic signed [XW-1:0] v);
        logic signed [CW-1:0] res;
        if (!v[XW-1] && (v[XW-2:CW-1] != '0)) begin
            res = C_MAX;
        end else if (v[XW-1] && !(&v[XW-2:CW-1])) begin
            res = C_MIN;
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    // Data that rides alongside the divider pipeline.
    typedef struct packed {
        logic                  sweep;
        logic                  fx;      // x face tried
        logic                  fy;      // y face tried
        logic                  hpos;    // mover_h + obstacle_h > 0
        logic signed [CW-1:0]  nx;
        logic signed [CW-1:0]  ny;
        logic [SW-1:0]         w;
        logic [SW-1:0]         h;
        logic signed [XW-1:0]  bx0;
        logic signed [XW-1:0]  bx1;
        logic signed [XW-1:0]  by0;
        logic signed [XW-1:0]  by1;
        logic signed [CW-1:0]  cx;      // x of x face contact
        logic signed [CW-1:0]  cy;      // y of y face contact
    } t_side;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [REG_BITS-1:0] r_gap;
    logic [REG_BITS-1:0] r_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
            r_lim <= LIM_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_CONTACT_GAP: r_gap <= i_cfg_data;
                REG_NEAR_ZERO:   r_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline never holds off an item.
    assign busy = 1'b0;

    logic w_accept;
    assign w_accept = start && !busy;

    // ---------------------------------------------------------------
    // Stage 0: capture the item
    // ---------------------------------------------------------------
    logic                 r0_v;
    logic signed [CW-1:0] r0_px, r0_py, r0_nx, r0_ny, r0_ox, r0_oy;
    logic [SW-1:0]        r0_w, r0_h, r0_ow, r0_oh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r0_px <= i_prev_x;
            r0_py <= i_prev_y;
            r0_nx <= i_next_x;
            r0_ny <= i_next_y;
            r0_w  <= i_mover_w;
            r0_h  <= i_mover_h;
            r0_ox <= i_obstacle_x;
            r0_oy <= i_obstacle_y;
            r0_ow <= i_obstacle_w;
            r0_oh <= i_obstacle_h;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: motion, swept box, obstacle box, doubled contact coordinate
    // All box edges are kept at twice the scale so half sizes stay exact.
    // ---------------------------------------------------------------
    logic signed [DW-1:0]  n1_dx, n1_dy;
    logic                  n1_dxp, n1_dyp, n1_mov;
    logic signed [XW-1:0]  n1_ws, n1_hs, n1_ows, n1_ohs;
    logic signed [XW-1:0]  n1_px2, n1_py2, n1_nx2, n1_ny2, n1_ox2, n1_oy2;
    logic signed [XW-1:0]  n1_zx0, n1_zx1, n1_zy0, n1_zy1;
    logic signed [XW-1:0]  n1_bx0, n1_bx1, n1_by0, n1_by1;
    logic signed [C2W-1:0] n1_g2, n1_c2x, n1_c2y;

    always_comb begin
        n1_dx  = DW'(r0_nx) - DW'(r0_px);
        n1_dy  = DW'(r0_ny) - DW'(r0_py);
        n1_dxp = !n1_dx[DW-1] && (n1_dx != '0);
        n1_dyp = !n1_dy[DW-1] && (n1_dy != '0);
        n1_mov = (n1_dx != '0) || (n1_dy != '0);
        n1_ws  = $signed({3'b000, r0_w});
        n1_hs  = $signed({3'b000, r0_h});
        n1_ows = $signed({3'b000, r0_ow});
        n1_ohs = $signed({3'b000, r0_oh});
        n1_px2 = XW'($signed({r0_px, 1'b0}));
        n1_py2 = XW'($signed({r0_py, 1'b0}));
        n1_nx2 = XW'($signed({r0_nx, 1'b0}));
        n1_ny2 = XW'($signed({r0_ny, 1'b0}));
        n1_ox2 = XW'($signed({r0_ox, 1'b0}));
        n1_oy2 = XW'($signed({r0_oy, 1'b0}));
        n1_zx0 = (n1_dxp ? n1_px2 : n1_nx2) - n1_ws;
        n1_zx1 = (n1_dxp ? n1_nx2 : n1_px2) + n1_ws;
        n1_zy0 = (n1_dyp ? n1_py2 : n1_ny2) - n1_hs;
        n1_zy1 = (n1_dyp ? n1_ny2 : n1_py2) + n1_hs;
        n1_bx0 = n1_ox2 - n1_ows;
        n1_bx1 = n1_ox2 + n1_ows;
        n1_by0 = n1_oy2 - n1_ohs;
        n1_by1 = n1_oy2 + n1_ohs;
        n1_g2  = C2W'($signed({1'b0, r_gap, 1'b0}));
        // approach from the left/below touches the near face, else the far one
        n1_c2x = n1_dxp ? (C2W'(n1_bx0) - C2W'(n1_ws) - n1_g2)
                        : (C2W'(n1_bx1) + C2W'(n1_ws) + n1_g2);
        n1_c2y = n1_dyp ? (C2W'(n1_by0) - C2W'(n1_hs) - n1_g2)
                        : (C2W'(n1_by1) + C2W'(n1_hs) + n1_g2);
    end

    logic                  r1_v, r1_mov, r1_hpos;
    logic signed [DW-1:0]  r1_dx, r1_dy;
    logic signed [XW-1:0]  r1_zx0, r1_zx1, r1_zy0, r1_zy1;
    logic signed [XW-1:0]  r1_bx0, r1_bx1, r1_by0, r1_by1;
    logic signed [C2W-1:0] r1_c2x, r1_c2y;
    logic signed [CW-1:0]  r1_nx, r1_ny;
    logic [SW-1:0]         r1_w, r1_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_mov  <= n1_mov;
        r1_hpos <= (r0_h != '0) || (r0_oh != '0);
        r1_dx   <= n1_dx;
        r1_dy   <= n1_dy;
        r1_zx0  <= n1_zx0;
        r1_zx1  <= n1_zx1;
        r1_zy0  <= n1_zy0;
        r1_zy1  <= n1_zy1;
        r1_bx0  <= n1_bx0;
        r1_bx1  <= n1_bx1;
        r1_by0  <= n1_by0;
        r1_by1  <= n1_by1;
        r1_c2x  <= n1_c2x;
        r1_c2y  <= n1_c2y;
        r1_nx   <= r0_nx;
        r1_ny   <= r0_ny;
        r1_w    <= r0_w;
        r1_h    <= r0_h;
    end

    // ---------------------------------------------------------------
    // Stage 2: broad phase, face selection, divider operands
    // x face: y = ny + floor(dy * (c2x - 2nx) / (2dx))
    // y face: x = nx + floor(dx * (c2y - 2ny) / (2dy))
    // ---------------------------------------------------------------
    logic                  n2_sweep, n2_fx, n2_fy;
    logic signed [DW-1:0]  n2_lim;
    logic signed [BNW-1:0] n2_bnx, n2_bny;
    logic [DW-1:0]         n2_adx, n2_ady;
    logic [BNW-1:0]        n2_ubx, n2_uby;
    t_side                 n2_side;

    always_comb begin
        n2_sweep = r1_mov && (r1_zx1 > r1_bx0) && (r1_zx0 < r1_bx1) &&
                   (r1_zy1 > r1_by0) && (r1_zy0 < r1_by1);
        n2_lim   = DW'($signed({1'b0, r_lim}));
        n2_fx    = n2_sweep && ((r1_dx > n2_lim) || (r1_dx < -n2_lim));
        n2_fy    = n2_sweep && ((r1_dy > n2_lim) || (r1_dy < -n2_lim));
        n2_bnx   = BNW'(r1_c2x) - BNW'($signed({r1_nx, 1'b0}));
        n2_bny   = BNW'(r1_c2y) - BNW'($signed({r1_ny, 1'b0}));
        n2_adx   = r1_dx[DW-1] ? DW'(-r1_dx) : DW'(r1_dx);
        n2_ady   = r1_dy[DW-1] ? DW'(-r1_dy) : DW'(r1_dy);
        n2_ubx   = n2_bnx[BNW-1] ? BNW'(-n2_bnx) : BNW'(n2_bnx);
        n2_uby   = n2_bny[BNW-1] ? BNW'(-n2_bny) : BNW'(n2_bny);

        n2_side.sweep = n2_sweep;
        n2_side.fx    = n2_fx;
        n2_side.fy    = n2_fy;
        n2_side.hpos  = r1_hpos;
        n2_side.nx    = r1_nx;
        n2_side.ny    = r1_ny;
        n2_side.w     = r1_w;
        n2_side.h     = r1_h;
        n2_side.bx0   = r1_bx0;
        n2_side.bx1   = r1_bx1;
        n2_side.by0   = r1_by0;
        n2_side.by1   = r1_by1;
        // floor(c2 / 2) is an arithmetic shift
        n2_side.cx    = sat_c(XW'(r1_c2x >>> 1));
        n2_side.cy    = sat_c(XW'(r1_c2y >>> 1));
    end

    logic                 r2_v;
    t_side                r2_side;
    logic                 r2_negx, r2_negy;
    logic [DW-1:0]        r2_uax, r2_uay;
    logic [BNW-1:0]       r2_ubx, r2_uby;
    logic [UCW-1:0]       r2_ucx, r2_ucy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_side <= n2_side;
        r2_negx <= r1_dy[DW-1] ^ n2_bnx[BNW-1] ^ r1_dx[DW-1];
        r2_negy <= r1_dx[DW-1] ^ n2_bny[BNW-1] ^ r1_dy[DW-1];
        r2_uax  <= n2_ady;
        r2_uay  <= n2_adx;
        r2_ubx  <= n2_ubx;
        r2_uby  <= n2_uby;
        r2_ucx  <= {n2_adx, 1'b0};
        r2_ucy  <= {n2_ady, 1'b0};
    end

    // ---------------------------------------------------------------
    // Line interpolation, one unit per face, both run every item
    // ---------------------------------------------------------------
    logic signed [CW-1:0] w_ty_x;   // y on the path at the x face
    logic signed [CW-1:0] w_tx_y;   // x on the path at the y face

    sbcr_muldiv #(.COORD_BITS(COORD_BITS)) u_div_x (
        .i_clk  (i_clk),
        .i_neg  (r2_negx),
        .i_ua   (r2_uax),
        .i_ub   (r2_ubx),
        .i_uc   (r2_ucx),
        .i_base (r2_side.ny),
        .o_val  (w_ty_x)
    );

    sbcr_muldiv #(.COORD_BITS(COORD_BITS)) u_div_y (
        .i_clk  (i_clk),
        .i_neg  (r2_negy),
        .i_ua   (r2_uay),
        .i_ub   (r2_uby),
        .i_uc   (r2_ucy),
        .i_base (r2_side.nx),
        .o_val  (w_tx_y)
    );

    // Side data and valid bits delayed to line up with the divider results.
    logic  r_sdv [0:LAT-1];
    t_side r_sd  [0:LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_sdv[k] <= 1'b0;
            end
        end else begin
            r_sdv[0] <= r2_v;
            for (int k = 1; k < LAT; k++) begin
                r_sdv[k] <= r_sdv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[0] <= r2_side;
        for (int k = 1; k < LAT; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    // ---------------------------------------------------------------
    // Final stage: range test on the other axis; x face wins a tie
    // ---------------------------------------------------------------
    t_side                n3_s;
    logic signed [XW-1:0] n3_ty2, n3_tx2, n3_hs, n3_ws;
    logic                 n3_hx, n3_hy;

    always_comb begin
        n3_s   = r_sd[LAT-1];
        n3_ty2 = XW'($signed({w_ty_x, 1'b0}));
        n3_tx2 = XW'($signed({w_tx_y, 1'b0}));
        n3_hs  = $signed({3'b000, n3_s.h});
        n3_ws  = $signed({3'b000, n3_s.w});
        n3_hx  = n3_s.fx && (n3_ty2 + n3_hs > n3_s.by0) && (n3_ty2 - n3_hs < n3_s.by1);
        n3_hy  = n3_s.fy && n3_s.hpos &&
                 (n3_tx2 + n3_ws > n3_s.bx0) && (n3_tx2 - n3_ws < n3_s.bx1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_sdv[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_in_sweep <= n3_s.sweep;
        o_hit      <= n3_hx || n3_hy;
        o_hit_side <= !n3_hx && n3_hy;
        o_out_x    <= n3_hx ? n3_s.cx : (n3_hy ? w_tx_y : n3_s.nx);
        o_out_y    <= n3_hx ? w_ty_x : (n3_hy ? n3_s.cy : n3_s.ny);
    end
endmodule
`default_nettype wire

// ===== rtl/sbcr_checker.sv =====
// Port level checks for the swept box contact resolver, bound to the top.
`default_nettype none
module sbcr_checker #(
    parameter int COORD_BITS = sbcr_pkg::DEF_COORD_BITS
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic signed [COORD_BITS-1:0] i_prev_x,
    input wire logic signed [COORD_BITS-1:0] i_prev_y,
    input wire logic signed [COORD_BITS-1:0] i_next_x,
    input wire logic signed [COORD_BITS-1:0] i_next_y,
    input wire logic                         o_valid,
    input wire logic                         o_in_sweep,
    input wire logic                         o_hit,
    input wire logic                         o_hit_side,
    input wire logic signed [COORD_BITS-1:0] o_out_x,
    input wire logic signed [COORD_BITS-1:0] o_out_y
);
    import sbcr_pkg::*;

    localparam int TOT = COORD_BITS + 9;

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, TOT))
        else $error("result without an accepted item");

    a_hit_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> o_in_sweep)
        else $error("hit outside the swept region");

    a_side_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_side) |-> o_hit)
        else $error("face reported without a hit");

    a_miss_keeps_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |->
            ((o_out_x == $past(i_next_x, TOT)) && (o_out_y == $past(i_next_y, TOT))))
        else $error("miss does not return the intended position");

    a_still_no_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past((i_prev_x == i_next_x) && (i_prev_y == i_next_y), TOT))
            |-> !o_in_sweep)
        else $error("zero motion reported in sweep");
endmodule

bind swept_box_contact_resolve_top sbcr_checker #(.COORD_BITS(COORD_BITS)) u_sbcr_checker (.*);
`default_nettype wire

// ===== tb/swept_box_contact_resolve_top_test.sv =====
// Testbench for the swept box contact resolver: random and directed moves.
`default_nettype none
module swept_box_contact_resolve_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sbcr_pkg::*;

    localparam int CB = 32;
    localparam int LATENCY = CB + 9;

    // one move: mover path and size, obstacle box
    typedef struct {
        logic signed [CB-1:0] px, py, nx, ny;
        logic [CB-2:0]        w, h;
        logic signed [CB-1:0] ox, oy;
        logic [CB-2:0]        ow, oh;
    } t_move;

    typedef struct {
        bit                   sweep, hit, side;
        logic signed [CB-1:0] rx, ry;
    } t_contact;

    int errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // floor(a*b/c), magnitude capped at 2^62, zero when c is zero
    function automatic longint scaled_quotient(longint a, longint b, longint c);
        logic signed [129:0] num, q, r, cap;
        if (c == 0) return 0;
        num = $signed(a) * $signed(b);
        q = num / c;
        r = num - q * c;
        if (r != 0 && ((r < 0) != (c < 0))) q = q - 1;
        cap = 130'sd1 <<< 62;
        if (q > cap) q = cap;
        if (q < -cap) q = -cap;
        return longint'(q);
    endfunction

    function automatic longint clamp_coord(longint v);
        longint hi;
        hi = (64'sd1 <<< (CB - 1)) - 1;
        return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
    endfunction

    function automatic longint floor_half(longint v);
        return v >>> 1;
    endfunction

    class t_contact_board;
        t_contact pending[$];
        longint   gap = 1, lim = 1;
        int       checked = 0, hits = 0, sweeps = 0;

        function t_contact resolve(t_move m);
            t_contact e;
            longint px, py, nx, ny, w, h, ox, oy, ow, oh, dx, dy, g2, c2, tx, ty;
            longint zx0, zx1, zy0, zy1, bx0, bx1, by0, by1;
            px = m.px; py = m.py; nx = m.nx; ny = m.ny;
            w = m.w; h = m.h; ox = m.ox; oy = m.oy; ow = m.ow; oh = m.oh;
            dx = nx - px; dy = ny - py; g2 = 2 * gap;
            e.sweep = 0; e.hit = 0; e.side = 0; e.rx = m.nx; e.ry = m.ny;
            if (dx == 0 && dy == 0) return e;
            zx0 = dx > 0 ? 2*px - w : 2*nx - w;
            zx1 = dx > 0 ? 2*nx + w : 2*px + w;
            zy0 = dy > 0 ? 2*py - h : 2*ny - h;
            zy1 = dy > 0 ? 2*ny + h : 2*py + h;
            bx0 = 2*ox - ow; bx1 = 2*ox + ow; by0 = 2*oy - oh; by1 = 2*oy + oh;
            e.sweep = zx1 > bx0 && zx0 < bx1 && zy1 > by0 && zy0 < by1;
            if (!e.sweep) return e;
            if (dx > lim || dx < -lim) begin
                c2 = dx > 0 ? bx0 - w - g2 : bx1 + w + g2;
                tx = clamp_coord(floor_half(c2));
                ty = clamp_coord(ny + scaled_quotient(dy, c2 - 2*nx, 2*dx));
                if (2*ty + h > by0 && 2*ty - h < by1) begin
                    e.hit = 1; e.side = 0; e.rx = tx; e.ry = ty;
                end
            end
            if (!e.hit && (dy > lim || dy < -lim)) begin
                c2 = dy > 0 ? by0 - h - g2 : by1 + h + g2;
                ty = clamp_coord(floor_half(c2));
                tx = clamp_coord(nx + scaled_quotient(dx, c2 - 2*ny, 2*dy));
                if (2*tx + w > bx0 && 2*tx - w < bx1 && h + oh > 0) begin
                    e.hit = 1; e.side = 1; e.rx = tx; e.ry = ty;
                end
            end
            return e;
        endfunction

        function void note_move(t_move m);
            pending.insert(pending.size(), resolve(m));
        endfunction

        task check_contact(t_contact got);
            t_contact want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            want = pending.pop_front();
            checked++;
            hits += want.hit;
            sweeps += want.sweep;
            if (got.sweep != want.sweep) report_mismatch("in_sweep", got.sweep, want.sweep);
            if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
            if (got.side != want.side) report_mismatch("hit_side", got.side, want.side);
            if (got.rx != want.rx) report_mismatch("out_x", got.rx, want.rx);
            if (got.ry != want.ry) report_mismatch("out_y", got.ry, want.ry);
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0, start = 0, busy;
    logic signed [CB-1:0] i_prev_x = 0, i_prev_y = 0, i_next_x = 0, i_next_y = 0;
    logic signed [CB-1:0] i_obstacle_x = 0, i_obstacle_y = 0;
    logic [CB-2:0] i_mover_w = 0, i_mover_h = 0, i_obstacle_w = 0, i_obstacle_h = 0;
    logic i_cfg_we = 0;
    logic [REG_IDX_BITS-1:0] i_cfg_addr = REG_CONTACT_GAP;
    logic [REG_BITS-1:0] i_cfg_data = 0;
    logic o_valid, o_in_sweep, o_hit, o_hit_side;
    logic signed [CB-1:0] o_out_x, o_out_y;

    t_contact_board board = new();
    int idle_pct = 13;

    swept_box_contact_resolve_top #(.COORD_BITS(CB)) dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // results cannot be held off; sample every strobe
    always @(posedge i_clk) begin
        t_contact got;
        if (i_rst_n && o_valid) begin
            got.sweep = o_in_sweep; got.hit = o_hit; got.side = o_hit_side;
            got.rx = o_out_x; got.ry = o_out_y;
            board.check_contact(got);
        end
    end

    initial begin
        #50ms;
        $display("status: fail");
        $finish;
    end

    task automatic write_reg(input t_reg_idx idx, input logic [REG_BITS-1:0] val);
        i_cfg_we <= 1; i_cfg_addr <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == REG_CONTACT_GAP) board.gap = val; else board.lim = val;
    endtask

    // drain results, then let the pipeline settle before a register write
    task automatic settle();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // start stays high across back to back items; lowered only on idle cycles
    task automatic send_move(input t_move m);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start <= 1;
        i_prev_x <= m.px; i_prev_y <= m.py; i_next_x <= m.nx; i_next_y <= m.ny;
        i_mover_w <= m.w; i_mover_h <= m.h;
        i_obstacle_x <= m.ox; i_obstacle_y <= m.oy;
        i_obstacle_w <= m.ow; i_obstacle_h <= m.oh;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_move(m);
    endtask

    task automatic stop_sending();
        start <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [CB-1:0] any_coord();
        return $urandom;
    endfunction

    // random move near an obstacle, sized so that contacts are common
    function automatic t_move near_move();
        t_move m;
        int span;
        span = 1 << $urandom_range(4, 22);
        m.ox = $signed($urandom_range(0, 2*span)) - span;
        m.oy = $signed($urandom_range(0, 2*span)) - span;
        m.ow = (CB-1)'($urandom_range(0, span)); m.oh = (CB-1)'($urandom_range(0, span));
        m.w = (CB-1)'($urandom_range(0, span)); m.h = (CB-1)'($urandom_range(0, span));
        m.px = m.ox + $signed($urandom_range(0, 4*span)) - 2*span;
        m.py = m.oy + $signed($urandom_range(0, 4*span)) - 2*span;
        case ($urandom_range(5))
            0: begin m.nx = m.px; m.ny = m.py + $signed($urandom_range(0, 4*span)) - 2*span; end
            1: begin m.ny = m.py; m.nx = m.px + $signed($urandom_range(0, 4*span)) - 2*span; end
            2: begin m.nx = m.px + $signed($urandom_range(0, 6)) - 3;
                     m.ny = m.py + $signed($urandom_range(0, 6)) - 3; end
            default: begin
                m.nx = m.ox + $signed($urandom_range(0, 2*span)) - span;
                m.ny = m.oy + $signed($urandom_range(0, 2*span)) - span;
            end
        endcase
        return m;
    endfunction

    function automatic t_move wild_move();
        t_move m;
        m.px = any_coord(); m.py = any_coord(); m.nx = any_coord(); m.ny = any_coord();
        m.ox = any_coord(); m.oy = any_coord();
        m.w = (CB-1)'($urandom); m.h = (CB-1)'($urandom);
        m.ow = (CB-1)'($urandom); m.oh = (CB-1)'($urandom);
        return m;
    endfunction

    function automatic t_move make_move(longint px, longint py, longint nx, longint ny,
                                        longint w, longint h, longint ox, longint oy,
                                        longint ow, longint oh);
        t_move m;
        m.px = CB'(px); m.py = CB'(py); m.nx = CB'(nx); m.ny = CB'(ny);
        m.w = (CB-1)'(w); m.h = (CB-1)'(h);
        m.ox = CB'(ox); m.oy = CB'(oy);
        m.ow = (CB-1)'(ow); m.oh = (CB-1)'(oh);
        return m;
    endfunction

    localparam longint ONE = 65536;
    localparam longint CMAX = 64'sh7FFF_FFFF;
    localparam longint CMIN = -64'sh8000_0000;
    localparam longint SMAX = 64'sh7FFF_FFFF;

    initial begin
        t_move m;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset register values first
        send_move(make_move(0, 0, 0, 0, ONE, ONE, 0, 0, ONE, ONE));          // zero motion
        send_move(make_move(-8*ONE, 0, 8*ONE, 0, ONE, ONE, 0, 0, 2*ONE, 2*ONE)); // x face, right
        send_move(make_move(8*ONE, 0, -8*ONE, 0, ONE, ONE, 0, 0, 2*ONE, 2*ONE)); // x face, left
        send_move(make_move(0, -8*ONE, 0, 8*ONE, ONE, ONE, 0, 0, 2*ONE, 2*ONE)); // y face, up
        send_move(make_move(0, 8*ONE, 0, -8*ONE, ONE, ONE, 0, 0, 2*ONE, 2*ONE)); // y face, down
        send_move(make_move(-8*ONE, -8*ONE, 8*ONE, 8*ONE, ONE, ONE, 0, 0, ONE, ONE)); // diagonal
        send_move(make_move(-8*ONE, 9*ONE, 8*ONE, 9*ONE, ONE, ONE, 0, 0, ONE, ONE)); // miss sweep
        send_move(make_move(0, -8*ONE, 1, 8*ONE, ONE, ONE, 0, 0, ONE, ONE));   // tiny x motion
        send_move(make_move(0, 0, 0, 0, ONE, ONE, 0, 0, 0, 0));                // zero sizes
        send_move(make_move(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE, 0));             // zero heights
        send_move(make_move(ONE, 0, 3*ONE, 0, 4*ONE, ONE, 2*ONE, 0, ONE, ONE)); // behind start
        send_move(make_move(CMIN, CMIN, CMAX, CMAX, SMAX, SMAX, 0, 0, SMAX, SMAX));
        send_move(make_move(CMAX, CMAX, CMIN, CMIN, 0, 0, CMAX, CMIN, SMAX, 1));
        send_move(make_move(CMIN, 0, CMIN + 2, CMAX, SMAX, SMAX, CMIN, CMAX, SMAX, SMAX));
        send_move(make_move(0, CMIN, 3, CMAX, 1, 1, 0, 0, 4, 4));              // huge slope
        send_move(make_move(-1, -1, 1, 1, 0, 0, 0, 0, 1, 1));
        stop_sending();
        settle();

        // extremes of both registers
        write_reg(REG_CONTACT_GAP, 16'hFFFF);
        write_reg(REG_NEAR_ZERO, 16'h0000);
        send_move(make_move(-8*ONE, 0, 8*ONE, 0, ONE, ONE, 0, 0, 2*ONE, 2*ONE));
        send_move(make_move(0, -8*ONE, 1, 8*ONE, ONE, ONE, 0, 0, ONE, ONE));
        send_move(make_move(CMIN, CMIN, CMAX, CMAX, SMAX, SMAX, CMIN, CMIN, SMAX, SMAX));
        stop_sending();
        settle();
        write_reg(REG_CONTACT_GAP, 16'h0000);
        write_reg(REG_NEAR_ZERO, 16'hFFFF);
        send_move(make_move(-8*ONE, 0, 8*ONE, 0, ONE, ONE, 0, 0, 2*ONE, 2*ONE));
        send_move(make_move(0, -8*ONE, ONE, 8*ONE, ONE, ONE, 0, 0, ONE, ONE));
        stop_sending();
        settle();

        // random phases, each with its own register setting
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_CONTACT_GAP, 16'd1);
                    write_reg(REG_NEAR_ZERO, 16'd1);
                end
                1: begin
                    write_reg(REG_CONTACT_GAP, 16'd0);
                    write_reg(REG_NEAR_ZERO, 16'd0);
                end
                2: begin
                    write_reg(REG_CONTACT_GAP, 16'hFFFF);
                    write_reg(REG_NEAR_ZERO, 16'hFFFF);
                end
                default: begin
                    write_reg(REG_CONTACT_GAP, REG_BITS'($urandom));
                    write_reg(REG_NEAR_ZERO, REG_BITS'($urandom_range(0, 8)));
                end
            endcase
            // phase 1 runs with no idling at all
            idle_pct = (phase == 1) ? 0 : 13;
            repeat (320) begin
                m = ($urandom_range(99) < 80) ? near_move() : wild_move();
                send_move(m);
            end
            stop_sending();
            settle();
        end

        $display("covered %0d moves: %0d in sweep, %0d contacts, register extremes exercised",
                 board.checked, board.sweeps, board.hits);
        if (errors == 0 && board.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/sbcr_pkg.sv
rtl/sbcr_muldiv.sv
rtl/swept_box_contact_resolve_top.sv
rtl/sbcr_checker.sv
tb/swept_box_contact_resolve_top_test.sv
